[rtl/core/sha1s_pkg.sv]
// shared types, constants and round functions for the sha-1 stream hasher
package sha1s_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned TDATA_W         = 40;
    localparam int unsigned ROUNDS          = 80;
    localparam logic [4:0]  DIGEST_BYTES_RST = 5'd20;
    localparam logic [4:0]  DIGEST_BYTES_MAX = 5'd20;
    localparam logic [3:0]  LEN_SLOT        = 4'd14;
    localparam logic [31:0] PAD_MARK        = 32'h8000_0000;

    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    typedef enum logic [3:0] {
        K_NONE   = 4'd0,
        K_DATA   = 4'd1,
        K_LDATA  = 4'd2,
        K_PART   = 4'd3,
        K_MARK   = 4'd4,
        K_ZERO   = 4'd5,
        K_LENHI  = 4'd6,
        K_LENLO  = 4'd7,
        K_DIGEST = 4'd8
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PUSH  = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef struct packed {
        logic [31:0] word;
        t_kind       kind;
        logic [5:0]  add_bits;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20) begin
            k = 32'h5A827999;
        end else if (t < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (t < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (t >= 7'd40 && t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

[rtl/core/sha1s_front.sv]
// input classification and item queue ahead of the compression engine
module sha1s_front import sha1s_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,   // data_word, word_bytes, zero fill
    input  logic               i_s_axis_tlast,
    input  logic               i_pop,
    output t_head              o_head
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_item            cls;
    logic [2:0]       nb;
    logic             wr_en, rd_en;

    // classify the incoming word
    always_comb begin
        nb           = (i_s_axis_tdata[34:32] > 3'd4) ? 3'd4 : i_s_axis_tdata[34:32];
        cls.word     = i_s_axis_tdata[31:0];
        cls.kind     = K_DATA;
        cls.add_bits = 6'd32;
        if (i_s_axis_tlast) begin
            cls.add_bits = {nb, 3'b000};
            case (nb)
                3'd0: begin
                    cls.kind = K_PART;
                    cls.word = PAD_MARK;
                end
                3'd1: begin
                    cls.kind = K_PART;
                    cls.word = {i_s_axis_tdata[31:24], 24'h800000};
                end
                3'd2: begin
                    cls.kind = K_PART;
                    cls.word = {i_s_axis_tdata[31:16], 16'h8000};
                end
                3'd3: begin
                    cls.kind = K_PART;
                    cls.word = {i_s_axis_tdata[31:8], 8'h80};
                end
                default: begin
                    cls.kind = K_LDATA;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign wr_en           = i_s_axis_tvalid && o_s_axis_tready;
    assign rd_en           = i_pop && o_head.valid;
    assign o_head.valid    = (r_cnt != '0);
    assign o_head.item     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= cls;
        end
    end

endmodule

[rtl/core/sha1s_back.sv]
// block loading, padding, 80-round compression and digest output
module sha1s_back import sha1s_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [4:0]         i_cfg_wr_data,
    input  t_head              i_head,
    output logic               o_pop,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // digest_word, digest_valid_bytes, zero fill
    output logic               o_m_axis_tlast
);

    t_state            r_state, n_state;
    t_kind             r_kind, n_kind;
    logic [4:0][31:0]  r_chain, n_chain;
    logic [31:0]       r_a, r_b, r_c, r_d, r_e;
    logic [31:0]       n_a, n_b, n_c, n_d, n_e;
    logic [31:0]       r_w [16];
    logic [6:0]        r_round, n_round;
    logic [3:0]        r_fill, n_fill;
    logic [63:0]       r_bits, n_bits;
    logic [2:0]        r_k, n_k;
    logic [4:0]        r_dbytes;
    logic              r_ovalid, n_ovalid;
    logic [31:0]       r_oword, n_oword;
    logic [2:0]        r_ovb, n_ovb;
    logic              r_olast, n_olast;

    logic              push_en, do_disp, sh_en, lastw;
    t_kind             push_kind, nk, disp_kind;
    logic [31:0]       push_word, w_new, tmp, sh_in, mask;
    logic [3:0]        fill_n;
    logic [4:0]        dlen, rem;
    logic [2:0]        vb;

    assign w_new = {r_w[13][30:0] ^ r_w[8][30:0] ^ r_w[2][30:0] ^ r_w[0][30:0],
                    r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};
    assign tmp   = {r_a[26:0], r_a[31:27]} + round_f(r_round, r_b, r_c, r_d)
                 + r_e + r_w[0] + round_k(r_round);
    assign fill_n = r_fill + 1'b1;

    always_comb begin
        dlen = r_dbytes;
        if (r_dbytes == 5'd0) begin
            dlen = 5'd1;
        end else if (r_dbytes > DIGEST_BYTES_MAX) begin
            dlen = DIGEST_BYTES_MAX;
        end
        rem   = dlen - {r_k, 2'b00};
        lastw = (rem <= 5'd4);
        vb    = lastw ? rem[2:0] : 3'd4;
        case (vb)
            3'd1:    mask = 32'hFF00_0000;
            3'd2:    mask = 32'hFFFF_0000;
            3'd3:    mask = 32'hFFFF_FF00;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_chain   = r_chain;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_e       = r_e;
        n_round   = r_round;
        n_fill    = r_fill;
        n_bits    = r_bits;
        n_k       = r_k;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_oword   = r_oword;
        n_ovb     = r_ovb;
        n_olast   = r_olast;
        o_pop     = 1'b0;
        push_en   = 1'b0;
        push_kind = K_NONE;
        push_word = '0;
        do_disp   = 1'b0;
        disp_kind = K_NONE;
        nk        = K_NONE;

        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop     = 1'b1;
                    push_en   = 1'b1;
                    push_kind = i_head.item.kind;
                    push_word = i_head.item.word;
                    n_bits    = r_bits + {58'd0, i_head.item.add_bits};
                end
            end
            S_PUSH: begin
                push_en   = 1'b1;
                push_kind = r_kind;
                case (r_kind)
                    K_MARK:  push_word = PAD_MARK;
                    K_LENHI: push_word = r_bits[63:32];
                    K_LENLO: push_word = r_bits[31:0];
                    default: push_word = '0;
                endcase
            end
            S_ROUND: begin
                n_e     = r_d;
                n_d     = r_c;
                n_c     = {r_b[1:0], r_b[31:2]};
                n_b     = r_a;
                n_a     = tmp;
                n_round = r_round + 1'b1;
                if (r_round == 7'(ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_chain[4] = r_chain[4] + r_e;
                do_disp    = 1'b1;
                disp_kind  = r_kind;
            end
            S_OUT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oword  = r_chain[r_k] & mask;
                    n_ovb    = vb;
                    n_olast  = lastw;
                    n_k      = r_k + 1'b1;
                    if (lastw) begin
                        n_chain = H_INIT;
                        n_fill  = '0;
                        n_bits  = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push_en) begin
            case (push_kind)
                K_LDATA: nk = K_MARK;
                K_PART, K_MARK, K_ZERO: nk = (fill_n == LEN_SLOT) ? K_LENHI : K_ZERO;
                K_LENHI: nk = K_LENLO;
                K_LENLO: nk = K_DIGEST;
                default: nk = K_NONE;
            endcase
            n_fill = fill_n;
            if (fill_n == 4'd0) begin
                n_state = S_ROUND;
                n_kind  = nk;
                n_round = '0;
                n_a     = r_chain[0];
                n_b     = r_chain[1];
                n_c     = r_chain[2];
                n_d     = r_chain[3];
                n_e     = r_chain[4];
            end else begin
                do_disp   = 1'b1;
                disp_kind = nk;
            end
        end

        if (do_disp) begin
            case (disp_kind)
                K_NONE: begin
                    n_state = S_IDLE;
                end
                K_DIGEST: begin
                    n_state = S_OUT;
                    n_k     = '0;
                end
                default: begin
                    n_state = S_PUSH;
                    n_kind  = disp_kind;
                end
            endcase
        end
    end

    assign sh_en = push_en || (r_state == S_ROUND);
    assign sh_in = push_en ? push_word : w_new;

    // message schedule window, oldest word at index 0
    always_ff @(posedge i_clk) begin
        if (sh_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= sh_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_NONE;
            r_chain  <= H_INIT;
            r_round  <= '0;
            r_fill   <= '0;
            r_bits   <= '0;
            r_k      <= '0;
            r_dbytes <= DIGEST_BYTES_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_chain  <= n_chain;
            r_round  <= n_round;
            r_fill   <= n_fill;
            r_bits   <= n_bits;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) begin
                r_dbytes <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_d     <= n_d;
        r_e     <= n_e;
        r_oword <= n_oword;
        r_ovb   <= n_ovb;
        r_olast <= n_olast;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'd0, r_ovb, r_oword};
    assign o_m_axis_tlast  = r_olast;

endmodule

[rtl/core/sha1_stream_hasher_top.sv]
// sha-1 stream hasher top level
//
// slave stream: one message word per transaction, tdata[31:0] the word with its
// first byte in bits 31..24, tdata[34:32] the valid byte count, tlast on the final
// word of a message. only the final word may carry fewer than four bytes.
// master stream: one digest word per transaction (h0 first), tdata[31:0] the
// word with unused low bytes zeroed, tdata[34:32] its valid bytes, tlast on the
// final digest word. the digest is cut to the configured byte count, 1 to 20.
// words are queued in front of the compression engine; the engine loads one
// word per cycle while the queue holds one and takes none while the rounds of
// a full 16-word block run, then adds the result into the chaining hash.
// after the last word it pushes padding at one word per cycle outside those
// rounds and runs one or two compressions; after the final add the output state
// registers the digest, one word per cycle while the receiver takes them.
// a stalled receiver holds the digest in the output register and the engine
// waits; the queue keeps accepting words until full. reset clears the queue,
// the chaining hash, the length and sets the digest length to 20 bytes.
module sha1_stream_hasher_top import sha1s_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [4:0]         i_cfg_wr_data,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,   // data_word, word_bytes, zero fill
    input  logic               i_s_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // digest_word, digest_valid_bytes, zero fill
    output logic               o_m_axis_tlast
);

    t_head head;
    logic  pop;

    sha1s_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_pop           (pop),
        .o_head          (head)
    );

    sha1s_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_head          (head),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

[rtl/core/sha1s_checker.sv]
// port checker for the sha-1 stream hasher and its bind
module sha1s_checker import sha1s_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [TDATA_W-1:0] o_m_axis_tdata,
    input logic               o_m_axis_tlast
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled digest transaction changed");

    a_byte_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[34:32] != 3'd0) &&
            (o_m_axis_tdata[34:32] <= 3'd4) && (o_m_axis_tdata[39:35] == 5'd0))
        else $error("digest byte count out of range");

    a_short_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[34:32] != 3'd4) |-> o_m_axis_tlast)
        else $error("partial digest word not marked last");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[34:32] == 3'd1) |-> o_m_axis_tdata[23:0] == 24'd0)
        else $error("digest bytes beyond count not zero");

endmodule

bind sha1_stream_hasher_top sha1s_checker u_sha1s_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

[verif/tb_sha1_stream_hasher_top.sv]
// testbench for the sha-1 stream hasher: predicts digests and checks the output stream
module tb_sha1_stream_hasher_top import sha1s_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES  = 250;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned MAX_PRINTS     = 40;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  valid_bytes;
        logic        last;
    } t_digest_beat;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               cfg_wr_en       = 1'b0;
    logic [4:0]         cfg_wr_data     = '0;
    logic               s_tvalid        = 1'b0;
    logic [TDATA_W-1:0] s_tdata         = '0;
    logic               s_tlast         = 1'b0;
    logic               m_tready        = 1'b0;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [TDATA_W-1:0] o_m_axis_tdata;
    logic               o_m_axis_tlast;

    // predictor state
    logic [31:0]  chain[5];
    logic [31:0]  block_buf[16];
    int unsigned  block_fill;
    logic [63:0]  msg_bits;
    logic [4:0]   digest_len;
    t_digest_beat digest_q[$];

    int unsigned  err_count   = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  rx_hold     = 0;
    bit           tx_quiet    = 1'b0;
    bit           rx_quiet    = 1'b0;

    sha1_stream_hasher_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic void restart_hash();
        chain[0] = 32'h67452301;
        chain[1] = 32'hEFCDAB89;
        chain[2] = 32'h98BADCFE;
        chain[3] = 32'h10325476;
        chain[4] = 32'hC3D2E1F0;
        for (int i = 0; i < 16; i++) block_buf[i] = '0;
        block_fill = 0;
        msg_bits   = '0;
    endfunction

    function automatic void compress_chain();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        for (int i = 0; i < 16; i++) w[i] = block_buf[i];
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                tmp = w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15];
                w[t & 15] = {tmp[30:0], tmp[31]};
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            tmp = {a[26:0], a[31:27]} + f + e + w[t & 15] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void load_block_word(input logic [31:0] w);
        block_buf[block_fill] = w;
        block_fill = (block_fill + 1) % 16;
        if (block_fill == 0) compress_chain();
    endfunction

    function automatic void predict_digest(input logic [31:0] data, input logic [2:0] nb,
                                           input logic lst);
        logic [31:0]  keep;
        int unsigned  n, dl, nw, vb;
        t_digest_beat beat;
        if (!lst) begin
            msg_bits += 64'd32;
            load_block_word(data);
            return;
        end
        n = (nb > 3'd4) ? 4 : nb;
        msg_bits += 64'(n * 8);
        if (n == 4) begin
            load_block_word(data);
            load_block_word(32'h8000_0000);
        end else begin
            keep = ~(32'hFFFF_FFFF >> (8 * n));
            load_block_word((data & keep) | (32'h80 << (24 - 8 * n)));
        end
        while (block_fill > 14) load_block_word('0);
        while (block_fill < 14) load_block_word('0);
        load_block_word(msg_bits[63:32]);
        load_block_word(msg_bits[31:0]);
        dl = digest_len;
        if (dl == 0) dl = 1;
        if (dl > 20) dl = 20;
        nw = (dl + 3) / 4;
        for (int i = 0; i < nw; i++) begin
            vb = dl - 4 * i;
            if (vb > 4) vb = 4;
            beat.word        = chain[i] & ~(32'hFFFF_FFFF >> (8 * vb));
            beat.valid_bytes = 3'(vb);
            beat.last        = (i + 1 == nw);
            digest_q.push_back(beat);
        end
        restart_hash();
    endfunction

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_PRINTS)
            $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input logic [31:0] data, input logic [2:0] nb, input logic lst);
        int unsigned gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, nb, data};
        s_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_digest(data, nb, lst);
    endtask

    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_digest_len(input logic [4:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        digest_len = v;
    endtask

    task automatic test_empty_message();
        send_word($urandom, 3'd0, 1'b1);
    endtask

    task automatic test_short_final_words();
        send_word(32'h616263A5, 3'd3, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        send_word(32'h0000_0000, 3'd7, 1'b1);
        // partial count on a non-final word still takes four bytes
        send_word(32'hFFFF_FFFF, 3'd1, 1'b0);
        send_word(32'h1234_5678, 3'd5, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    endtask

    task automatic test_padding_overflow();
        for (int i = 0; i < 14; i++)
            send_word((i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd6, 1'b0);
        send_word(32'hA5C3_5A3C, 3'd2, 1'b1);
    endtask

    task automatic test_random_messages(input int unsigned budget, input bit quiet);
        int unsigned sent, nw, r;
        logic [2:0]  nb;
        sent     = 0;
        tx_quiet = quiet;
        rx_quiet = quiet;
        while (sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) nw = $urandom_range(0, 18);
            else if (r < 95) nw = $urandom_range(19, 40);
            else nw = $urandom_range(60, 80);
            for (int i = 0; i < nw; i++) begin
                nb = $urandom_range(0, 3) ? 3'd4 : 3'($urandom_range(0, 7));
                send_word($urandom, nb, 1'b0);
            end
            nb = $urandom_range(0, 1) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
            send_word($urandom, nb, 1'b1);
            sent += nw + 1;
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
            rx_hold  <= pick_gap(1'b0);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_digest_beat want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected digest word", o_m_axis_tdata[31:0], '0);
            end else begin
                want = digest_q.pop_front();
                if (o_m_axis_tdata[31:0] !== want.word)
                    report_mismatch("digest_word", o_m_axis_tdata[31:0], want.word);
                if (o_m_axis_tdata[34:32] !== want.valid_bytes)
                    report_mismatch("digest_valid_bytes", 32'(o_m_axis_tdata[34:32]),
                                    32'(want.valid_bytes));
                if (o_m_axis_tlast !== want.last)
                    report_mismatch("digest_last", 32'(o_m_axis_tlast), 32'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        restart_hash();
        digest_len = 5'd20;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_message();
        test_short_final_words();
        test_padding_overflow();
        wait_for_idle();

        set_digest_len(5'd1);
        test_random_messages(30, 1'b0);
        wait_for_idle();
        set_digest_len(5'd0);
        test_random_messages(20, 1'b0);
        wait_for_idle();
        set_digest_len(5'd31);
        test_random_messages(20, 1'b0);
        wait_for_idle();
        set_digest_len(5'd20);
        test_random_messages(30, 1'b1);
        wait_for_idle();
        for (int i = 0; i < 4; i++) begin
            set_digest_len(5'($urandom_range(0, 31)));
            test_random_messages(15, 1'b0);
            wait_for_idle();
        end

        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/core/sha1s_pkg.sv
rtl/core/sha1s_front.sv
rtl/core/sha1s_back.sv
rtl/core/sha1_stream_hasher_top.sv
rtl/core/sha1s_checker.sv
verif/tb_sha1_stream_hasher_top.sv
